[rtl/afp_pkg.sv]
// ----------------------------------------------------------------------------
// afp_pkg: shared types and constants of the flight autopilot
// Holds the fixed-point constants, controller gains, register indexes,
// the classified item format and the arctangent table used by the CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

package afp_pkg;

   // Fixed-point format and internal widths.
   localparam int FRAC_BITS = 16;
   localparam int ATAN_LEN  = 24;
   localparam int EW        = 28;   // controller error operands
   localparam int KW        = 18;   // gains
   localparam int PW        = EW + KW;
   localparam int AW        = 32;   // accumulator
   localparam int XW        = 35;   // CORDIC vector

   // Angle and limit constants in Q16.16.
   localparam logic signed [31:0] ONE_Q    = 32'sd65536;
   localparam logic signed [31:0] DEG_10   = 32'sd655360;
   localparam logic signed [31:0] DEG_30   = 32'sd1966080;
   localparam logic signed [31:0] DEG_90   = 32'sd5898240;
   localparam logic signed [31:0] DEG_180  = 32'sd11796480;
   localparam logic signed [31:0] DEG_360  = 32'sd23592960;
   localparam logic signed [31:0] DEG_250  = 32'sd16384000;
   localparam logic        [31:0] ALT_1500 = 32'd98304000;

   // Controller gains, rounded to nearest in Q16.16.
   localparam logic signed [KW-1:0] K_ROLL_P  = 18'sd655;
   localparam logic signed [KW-1:0] K_ROLL_D  = 18'sd58982;
   localparam logic signed [KW-1:0] K_FINE_P  = 18'sd13107;
   localparam logic signed [KW-1:0] K_FINE_D  = 18'sd13107;
   localparam logic signed [KW-1:0] K_PITCH_P = 18'sd19661;
   localparam logic signed [KW-1:0] K_PITCH_D = 18'sd65536;
   localparam logic signed [KW-1:0] K_SPEED_P = 18'sd1311;
   localparam logic signed [KW-1:0] K_SPEED_I = 18'sd262;

   // Fixed elevator pulls while hard turning.
   localparam logic signed [17:0] ELEV_SOFT = -18'sd19661;
   localparam logic signed [17:0] ELEV_HARD = -18'sd58982;

   // Register indexes.
   localparam logic [2:0] REG_ALT_BAND_MIN   = 3'd0;
   localparam logic [2:0] REG_ALT_BAND_MAX   = 3'd1;
   localparam logic [2:0] REG_HEAD_BAND_MIN  = 3'd2;
   localparam logic [2:0] REG_HEAD_BAND_MAX  = 3'd3;
   localparam logic [2:0] REG_THETA_BAND_MIN = 3'd4;
   localparam logic [2:0] REG_THETA_BAND_MAX = 3'd5;
   localparam logic [2:0] REG_ROLL_LIMIT     = 3'd6;
   localparam logic [2:0] REG_PITCH_REF_SCALE = 3'd7;

   // Register reset values.
   localparam logic [30:0] RST_ALT_MIN   = 31'd65536000;
   localparam logic [30:0] RST_ALT_MAX   = 31'd327680000;
   localparam logic [23:0] RST_HEAD_MIN  = 24'd1310720;
   localparam logic [23:0] RST_HEAD_MAX  = 24'd1966080;
   localparam logic [22:0] RST_THETA_MIN = 23'd327680;
   localparam logic [22:0] RST_THETA_MAX = 23'd655360;
   localparam logic [23:0] RST_ROLL_LIM  = 24'd5898240;
   localparam logic [30:0] RST_REF_SCALE = 31'd131072000;

   // Configuration as seen by the controller.
   typedef struct packed {
      logic [30:0] alt_min;
      logic [30:0] alt_max;
      logic [23:0] head_min;
      logic [23:0] head_max;
      logic [22:0] theta_min;
      logic [22:0] theta_max;
      logic [23:0] roll_limit;
      logic [30:0] ref_scale;
   } cfg_type;

   // One accepted tick with its precomputed magnitudes and flags.
   typedef struct packed {
      logic signed [24:0] head;
      logic signed [31:0] alt;
      logic signed [24:0] phi;
      logic signed [23:0] theta;
      logic        [25:0] spd;
      logic        [25:0] tgt;
      logic        [24:0] abs_head;
      logic        [31:0] abs_alt;
      logic        [24:0] abs_phi;
      logic        [23:0] abs_theta;
      logic               alt_big;
      logic               alt_small;
      logic               head_small;
      logic               head_pos;
      logic               spd_off;
   } item_type;

   // atan(2^-i) in degrees, Q8.24 source values rounded to FRAC_BITS.
   function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] q24;
      case (idx)
         5'd0:  q24 = 32'd754974720;
         5'd1:  q24 = 32'd445687602;
         5'd2:  q24 = 32'd235489088;
         5'd3:  q24 = 32'd119537938;
         5'd4:  q24 = 32'd60000934;
         5'd5:  q24 = 32'd30029717;
         5'd6:  q24 = 32'd15018523;
         5'd7:  q24 = 32'd7509720;
         5'd8:  q24 = 32'd3754917;
         5'd9:  q24 = 32'd1877466;
         5'd10: q24 = 32'd938734;
         5'd11: q24 = 32'd469367;
         5'd12: q24 = 32'd234684;
         5'd13: q24 = 32'd117342;
         5'd14: q24 = 32'd58671;
         5'd15: q24 = 32'd29335;
         5'd16: q24 = 32'd14668;
         5'd17: q24 = 32'd7334;
         5'd18: q24 = 32'd3667;
         5'd19: q24 = 32'd1833;
         5'd20: q24 = 32'd917;
         5'd21: q24 = 32'd458;
         5'd22: q24 = 32'd229;
         5'd23: q24 = 32'd115;
         default: q24 = 32'd0;
      endcase
      return $signed((q24 + (32'd1 << (24 - FRAC_BITS - 1))) >> (24 - FRAC_BITS));
   endfunction

endpackage

`default_nettype wire

[rtl/hysteretic_flight_autopilot.sv]
// ----------------------------------------------------------------------------
// hysteretic_flight_autopilot: heading, altitude and speed hold autopilot
// Holds the control registers and joins the intake queue to the controller.
//
//   Channel  Direction  Handshake             Payload
//   req_     in         push / full           six tick fields
//   rsp_     out        empty / pop           aileron, elevator, throttle
//   csr_     in         we, index, wdata      eight band and limit registers
//
// The work per item is set by the CORDIC loop, which hard turning skips, and
// by the single shared multiplier.
// Reset clears the queue, the result register and the controller memory and
// loads the register reset values; no clearing pass is needed.
// Up to two items queue while the controller is busy or a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteretic_flight_autopilot #(
   parameter int CORDIC_STEPS = 16,
   parameter int DIVE_LIMIT   = -1966080,
   parameter int CLIMB_LIMIT  = 1966080
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_push,
   output logic                req_full,
   input  wire  signed [24:0]  req_heading_error,
   input  wire  signed [31:0]  req_altitude_error,
   input  wire  signed [24:0]  req_roll_angle,
   input  wire  signed [23:0]  req_pitch_angle,
   input  wire         [25:0]  req_airspeed,
   input  wire         [25:0]  req_target_airspeed,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output logic signed [17:0]  rsp_aileron_cmd,
   output logic signed [17:0]  rsp_elevator_cmd,
   output logic signed [17:0]  rsp_throttle_cmd,
   input  wire                 csr_we,
   input  wire         [2:0]   csr_index,
   input  wire         [30:0]  csr_wdata
);
   import afp_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type head_item;
   logic     head_valid;
   logic     head_pop;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ALT_BAND_MIN:    cfg_in.alt_min    = csr_wdata;
            REG_ALT_BAND_MAX:    cfg_in.alt_max    = csr_wdata;
            REG_HEAD_BAND_MIN:   cfg_in.head_min   = csr_wdata[23:0];
            REG_HEAD_BAND_MAX:   cfg_in.head_max   = csr_wdata[23:0];
            REG_THETA_BAND_MIN:  cfg_in.theta_min  = csr_wdata[22:0];
            REG_THETA_BAND_MAX:  cfg_in.theta_max  = csr_wdata[22:0];
            REG_ROLL_LIMIT:      cfg_in.roll_limit = csr_wdata[23:0];
            REG_PITCH_REF_SCALE: cfg_in.ref_scale  = csr_wdata;
            default:             cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alt_min    <= RST_ALT_MIN;
         cfg_ff.alt_max    <= RST_ALT_MAX;
         cfg_ff.head_min   <= RST_HEAD_MIN;
         cfg_ff.head_max   <= RST_HEAD_MAX;
         cfg_ff.theta_min  <= RST_THETA_MIN;
         cfg_ff.theta_max  <= RST_THETA_MAX;
         cfg_ff.roll_limit <= RST_ROLL_LIM;
         cfg_ff.ref_scale  <= RST_REF_SCALE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Intake and classification.
   afp_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_heading_error   (req_heading_error),
      .req_altitude_error  (req_altitude_error),
      .req_roll_angle      (req_roll_angle),
      .req_pitch_angle     (req_pitch_angle),
      .req_airspeed        (req_airspeed),
      .req_target_airspeed (req_target_airspeed),
      .head_item           (head_item),
      .head_valid          (head_valid),
      .head_pop            (head_pop)
   );

   // Controller and result register.
   afp_back #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .DIVE_LIMIT   (DIVE_LIMIT),
      .CLIMB_LIMIT  (CLIMB_LIMIT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .item             (head_item),
      .item_valid       (head_valid),
      .item_pop         (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_aileron_cmd  (rsp_aileron_cmd),
      .rsp_elevator_cmd (rsp_elevator_cmd),
      .rsp_throttle_cmd (rsp_throttle_cmd)
   );

endmodule

`default_nettype wire

[rtl/afp_front.sv]
// ----------------------------------------------------------------------------
// afp_front: intake and classification of control ticks
// Takes items from the request side, derives magnitudes and fixed-threshold
// flags, and holds them in a two-entry queue for the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module afp_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_push,
   output logic                     req_full,
   input  wire  signed [24:0]       req_heading_error,
   input  wire  signed [31:0]       req_altitude_error,
   input  wire  signed [24:0]       req_roll_angle,
   input  wire  signed [23:0]       req_pitch_angle,
   input  wire         [25:0]       req_airspeed,
   input  wire         [25:0]       req_target_airspeed,
   output afp_pkg::item_type        head_item,
   output logic                     head_valid,
   input  wire                      head_pop
);
   import afp_pkg::*;

   item_type   new_item;
   item_type   q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   // Classify the incoming item.
   always_comb begin
      new_item.head       = req_heading_error;
      new_item.alt        = req_altitude_error;
      new_item.phi        = req_roll_angle;
      new_item.theta      = req_pitch_angle;
      new_item.spd        = req_airspeed;
      new_item.tgt        = req_target_airspeed;
      new_item.abs_head   = req_heading_error[24] ? 25'(-req_heading_error)
                                                  : 25'(req_heading_error);
      new_item.abs_alt    = req_altitude_error[31] ? 32'(-req_altitude_error)
                                                   : 32'(req_altitude_error);
      new_item.abs_phi    = req_roll_angle[24] ? 25'(-req_roll_angle)
                                               : 25'(req_roll_angle);
      new_item.abs_theta  = req_pitch_angle[23] ? 24'(-req_pitch_angle)
                                                : 24'(req_pitch_angle);
      new_item.alt_big    = new_item.abs_alt > ALT_1500;
      new_item.alt_small  = new_item.abs_alt < ALT_1500;
      new_item.head_small = new_item.abs_head < 25'(DEG_10);
      new_item.head_pos   = !req_heading_error[24];
      new_item.spd_off    = req_target_airspeed == 26'd0;
   end

   // Queue pointers and fill count.
   assign req_full   = cnt_ff == 2'd2;
   assign head_valid = cnt_ff != 2'd0;
   assign head_item  = q_ff[rd_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = head_pop && head_valid;

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

[rtl/afp_back.sv]
// ----------------------------------------------------------------------------
// afp_back: mode selection, control laws and result register
// A sequencer runs the roll, pitch and throttle controllers on one shared
// multiplier, iterates a CORDIC for the pitch reference and keeps the bands.
// ----------------------------------------------------------------------------
`default_nettype none

module afp_back #(
   parameter int CORDIC_STEPS = 16,
   parameter int DIVE_LIMIT   = -1966080,
   parameter int CLIMB_LIMIT  = 1966080
) (
   input  wire                      clock,
   input  wire                      reset,
   input  afp_pkg::cfg_type         cfg,
   input  afp_pkg::item_type        item,
   input  wire                      item_valid,
   output logic                     item_pop,
   output logic                     rsp_empty,
   input  wire                      rsp_pop,
   output logic signed [17:0]       rsp_aileron_cmd,
   output logic signed [17:0]       rsp_elevator_cmd,
   output logic signed [17:0]       rsp_throttle_cmd
);
   import afp_pkg::*;

   localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int CNT_W = $clog2(NSTEP + 1);
   localparam logic signed [31:0] DIVE_Q  = 32'(DIVE_LIMIT);
   localparam logic signed [31:0] CLIMB_Q = 32'(CLIMB_LIMIT);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_ROLL   = 4'd1;
   localparam logic [3:0] ST_MUL1   = 4'd2;
   localparam logic [3:0] ST_MUL2   = 4'd3;
   localparam logic [3:0] ST_MUL3   = 4'd4;
   localparam logic [3:0] ST_POST   = 4'd5;
   localparam logic [3:0] ST_CORDIC = 4'd6;
   localparam logic [3:0] ST_PITCH  = 4'd7;
   localparam logic [3:0] ST_SPEED  = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   // Which controller the shared multiply sequence serves.
   localparam logic [1:0] PH_ROLL  = 2'd0;
   localparam logic [1:0] PH_PITCH = 2'd1;
   localparam logic [1:0] PH_SPEED = 2'd2;

   logic [3:0]             state_ff, state_in;
   logic [1:0]             phase_ff, phase_in;
   logic                   hard_ff, hard_in;
   logic                   fine_ff, fine_in;
   logic signed [24:0]     ref_ff, ref_in;
   logic signed [17:0]     ail_ff, ail_in;
   logic signed [17:0]     elev_ff, elev_in;
   logic signed [17:0]     thr_ff, thr_in;
   logic [30:0]            alt_band_ff, alt_band_in;
   logic [23:0]            head_band_ff, head_band_in;
   logic [22:0]            theta_band_ff, theta_band_in;
   logic signed [EW-1:0]   roll_prev_ff, roll_prev_in;
   logic signed [EW-1:0]   fine_prev_ff, fine_prev_in;
   logic signed [EW-1:0]   pitch_prev_ff, pitch_prev_in;
   logic signed [EW-1:0]   speed_int_ff, speed_int_in;
   logic signed [KW-1:0]   k1_ff, k1_in, k2_ff, k2_in;
   logic signed [EW-1:0]   a1_ff, a1_in, a2_ff, a2_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [AW-1:0]   acc_ff, acc_in;
   logic signed [XW-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [31:0]     z_ff, z_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   out_valid_ff, out_valid_in;
   logic signed [17:0]     out_ail_ff, out_ail_in;
   logic signed [17:0]     out_elev_ff, out_elev_in;
   logic signed [17:0]     out_thr_ff, out_thr_in;

   logic signed [PW-1:0]   prod_rnd;
   logic signed [AW-1:0]   rnd_val;
   logic                   hard_now;
   logic signed [26:0]     rlim_s;
   logic signed [26:0]     ref_sel;
   logic signed [26:0]     phi_margin;
   logic signed [26:0]     diff;
   logic signed [EW-1:0]   err;
   logic signed [AW:0]     neg_acc;
   logic signed [XW-1:0]   xs, ys;
   logic signed [31:0]     ang;
   logic signed [31:0]     tref;
   logic signed [EW:0]     int_sum;

   assign rsp_empty        = !out_valid_ff;
   assign rsp_aileron_cmd  = out_ail_ff;
   assign rsp_elevator_cmd = out_elev_ff;
   assign rsp_throttle_cmd = out_thr_ff;

   // Rounded product: add one half, then floor shift.
   assign prod_rnd = prod_ff + PW'(32'sd1 <<< (FRAC_BITS - 1));
   assign rnd_val  = AW'(prod_rnd >>> FRAC_BITS);

   // Datapath helpers.
   assign hard_now   = (item.abs_head >= 25'(head_band_ff))
                    && (item.abs_alt <= 32'(alt_band_ff));
   assign rlim_s     = $signed({3'b000, cfg.roll_limit});
   assign phi_margin = rlim_s - $signed({2'b00, item.abs_phi});
   assign neg_acc    = -(AW + 1)'(acc_ff);
   assign xs         = x_ff >>> cnt_ff;
   assign ys         = y_ff >>> cnt_ff;
   assign ang        = atan_entry(5'(cnt_ff));
   assign int_sum    = (EW + 1)'(speed_int_ff) + (EW + 1)'(err);

   // Single shared multiplier.
   assign prod_in = (state_ff == ST_MUL1) ? PW'(k1_ff) * PW'(a1_ff)
                                          : PW'(k2_ff) * PW'(a2_ff);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      hard_in       = hard_ff;
      fine_in       = fine_ff;
      ref_in        = ref_ff;
      ail_in        = ail_ff;
      elev_in       = elev_ff;
      thr_in        = thr_ff;
      alt_band_in   = alt_band_ff;
      head_band_in  = head_band_ff;
      theta_band_in = theta_band_ff;
      roll_prev_in  = roll_prev_ff;
      fine_prev_in  = fine_prev_ff;
      pitch_prev_in = pitch_prev_ff;
      speed_int_in  = speed_int_ff;
      k1_in         = k1_ff;
      k2_in         = k2_ff;
      a1_in         = a1_ff;
      a2_in         = a2_ff;
      acc_in        = acc_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      cnt_in        = cnt_ff;
      out_ail_in    = out_ail_ff;
      out_elev_in   = out_elev_ff;
      out_thr_in    = out_thr_ff;
      item_pop      = 1'b0;
      ref_sel       = '0;
      diff          = '0;
      err           = '0;
      tref          = '0;

      // The result register drains independently of the sequencer.
      out_valid_in = out_valid_ff && !rsp_pop;

      case (state_ff)
         // Pick the mode, update the bands and prepare the roll reference.
         ST_IDLE: begin
            if (item_valid) begin
               hard_in = hard_now;
               fine_in = 1'b0;
               if (hard_now) begin
                  alt_band_in  = cfg.alt_max;
                  head_band_in = (cfg.head_min < cfg.head_max) ? cfg.head_min
                                                               : cfg.head_max;
                  ref_sel      = item.head_pos ? rlim_s : -rlim_s;
                  elev_in      = (phi_margin < 27'(DEG_30)) ? ELEV_SOFT : ELEV_HARD;
               end else begin
                  alt_band_in  = cfg.alt_min;
                  head_band_in = cfg.head_max;
                  if (item.alt_big) begin
                     theta_band_in = cfg.theta_max;
                  end else if (item.alt_small
                               && (item.abs_theta > 24'(theta_band_ff))) begin
                     theta_band_in = cfg.theta_min;
                  end else begin
                     theta_band_in = cfg.theta_max;
                     if (item.head_small) begin
                        ref_sel = 27'(item.head);
                        fine_in = 1'b1;
                     end else begin
                        ref_sel = 27'(item.head) * 27'sd3;
                     end
                  end
               end
               if (ref_sel > 27'(DEG_180)) begin
                  ref_in = 25'(DEG_180);
               end else if (ref_sel < -27'(DEG_180)) begin
                  ref_in = -25'(DEG_180);
               end else begin
                  ref_in = 25'(ref_sel);
               end
               x_in     = $signed({4'b0000, cfg.ref_scale});
               y_in     = XW'(item.alt);
               z_in     = '0;
               cnt_in   = '0;
               state_in = ST_ROLL;
            end
         end

         // Wrapped roll error and operands of the selected roll PID.
         ST_ROLL: begin
            diff = 27'(ref_ff) - 27'(item.phi);
            if (diff > 27'(DEG_180)) begin
               diff = diff - 27'(DEG_360);
            end else if (diff <= -27'(DEG_180)) begin
               diff = diff + 27'(DEG_360);
            end
            err   = -EW'(diff);
            a1_in = err;
            if (fine_ff) begin
               k1_in        = K_FINE_P;
               k2_in        = K_FINE_D;
               a2_in        = err - fine_prev_ff;
               fine_prev_in = err;
            end else begin
               k1_in        = K_ROLL_P;
               k2_in        = K_ROLL_D;
               a2_in        = err - roll_prev_ff;
               roll_prev_in = err;
            end
            phase_in = PH_ROLL;
            state_in = ST_MUL1;
         end

         // Two products through the shared multiplier, then their sum.
         ST_MUL1: begin
            state_in = ST_MUL2;
         end

         ST_MUL2: begin
            acc_in   = rnd_val;
            state_in = ST_MUL3;
         end

         ST_MUL3: begin
            acc_in   = acc_ff + rnd_val;
            state_in = ST_POST;
         end

         // Saturate the controller output and move on.
         ST_POST: begin
            case (phase_ff)
               PH_ROLL: begin
                  if (neg_acc > (AW + 1)'(ONE_Q)) begin
                     ail_in = 18'(ONE_Q);
                  end else if (neg_acc < -(AW + 1)'(ONE_Q)) begin
                     ail_in = -18'(ONE_Q);
                  end else begin
                     ail_in = 18'(neg_acc);
                  end
                  state_in = hard_ff ? ST_SPEED : ST_CORDIC;
               end
               PH_PITCH: begin
                  if (acc_ff > ONE_Q) begin
                     elev_in = 18'(ONE_Q);
                  end else if (acc_ff < -ONE_Q) begin
                     elev_in = -18'(ONE_Q);
                  end else begin
                     elev_in = 18'(acc_ff);
                  end
                  state_in = ST_SPEED;
               end
               default: begin
                  if (acc_ff > ONE_Q) begin
                     thr_in = 18'(ONE_Q);
                  end else if (acc_ff < 32'sd0) begin
                     thr_in = '0;
                  end else begin
                     thr_in = 18'(acc_ff);
                  end
                  state_in = ST_OUT;
               end
            endcase
         end

         // One vectoring step per cycle; a zero y leaves the vector alone.
         ST_CORDIC: begin
            if (cnt_ff < CNT_W'(NSTEP)) begin
               if (y_ff[XW-1]) begin
                  x_in = x_ff - ys;
                  y_in = y_ff + xs;
                  z_in = z_ff - ang;
               end else if (y_ff != '0) begin
                  x_in = x_ff + ys;
                  y_in = y_ff - xs;
                  z_in = z_ff + ang;
               end
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_PITCH;
            end
         end

         // Clamp the pitch reference and prepare the pitch PID.
         ST_PITCH: begin
            tref = z_ff;
            if (tref < DIVE_Q) begin
               tref = DIVE_Q;
            end else if (tref > CLIMB_Q) begin
               tref = CLIMB_Q;
            end
            if (tref < -DEG_90) begin
               tref = -DEG_90;
            end else if (tref > DEG_90) begin
               tref = DEG_90;
            end
            err           = EW'(item.theta) - EW'(tref);
            a1_in         = err;
            a2_in         = err - pitch_prev_ff;
            pitch_prev_in = err;
            k1_in         = K_PITCH_P;
            k2_in         = K_PITCH_D;
            phase_in      = PH_PITCH;
            state_in      = ST_MUL1;
         end

         // Speed hold: proportional on the error, integral on the clamp; a zero target sets the throttle to minus one.
         ST_SPEED: begin
            if (item.spd_off) begin
               thr_in   = -18'(ONE_Q);
               state_in = ST_OUT;
            end else begin
               err = $signed({2'b00, item.tgt}) - $signed({2'b00, item.spd});
               if (int_sum < (EW + 1)'(0)) begin
                  speed_int_in = '0;
               end else if (int_sum > (EW + 1)'(DEG_250)) begin
                  speed_int_in = EW'(DEG_250);
               end else begin
                  speed_int_in = EW'(int_sum);
               end
               a1_in    = err;
               a2_in    = speed_int_in;
               k1_in    = K_SPEED_P;
               k2_in    = K_SPEED_I;
               phase_in = PH_SPEED;
               state_in = ST_MUL1;
            end
         end

         // Hand the result over once the result register is free.
         ST_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_ail_in   = ail_ff;
               out_elev_in  = elev_ff;
               out_thr_in   = thr_ff;
               item_pop     = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and controller memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         alt_band_ff   <= RST_ALT_MIN;
         head_band_ff  <= RST_HEAD_MIN;
         theta_band_ff <= RST_THETA_MIN;
         roll_prev_ff  <= '0;
         fine_prev_ff  <= '0;
         pitch_prev_ff <= '0;
         speed_int_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         alt_band_ff   <= alt_band_in;
         head_band_ff  <= head_band_in;
         theta_band_ff <= theta_band_in;
         roll_prev_ff  <= roll_prev_in;
         fine_prev_ff  <= fine_prev_in;
         pitch_prev_ff <= pitch_prev_in;
         speed_int_ff  <= speed_int_in;
      end
   end

   // Working registers of the datapath.
   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      hard_ff     <= hard_in;
      fine_ff     <= fine_in;
      ref_ff      <= ref_in;
      ail_ff      <= ail_in;
      elev_ff     <= elev_in;
      thr_ff      <= thr_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      a1_ff       <= a1_in;
      a2_ff       <= a2_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      cnt_ff      <= cnt_in;
      out_ail_ff  <= out_ail_in;
      out_elev_ff <= out_elev_in;
      out_thr_ff  <= out_thr_in;
   end

endmodule

`default_nettype wire
